FILE: rtl/core/prq_pkg.sv
// ----------------------------------------------------------------------------
// prq_pkg
// Shared sizes, operation codes and types of the priority ready queue.
// ----------------------------------------------------------------------------
package prq_pkg;

    localparam int THREADS         = 16;
    localparam int PRIORITY_LEVELS = 32;

    localparam int ID_W   = $clog2(THREADS);
    localparam int TAG_W  = ID_W;
    localparam int PRIO_W = $clog2(PRIORITY_LEVELS);
    localparam int CNT_W  = $clog2(THREADS + 1);
    localparam int QW     = 16;

    localparam logic [QW-1:0] QUANTUM_RESET = 16'd10;

    // request functions
    localparam logic [2:0] FN_INSERT     = 3'd0;
    localparam logic [2:0] FN_REMOVE     = 3'd1;
    localparam logic [2:0] FN_SETPRIO    = 3'd2;
    localparam logic [2:0] FN_TICK       = 3'd3;
    localparam logic [2:0] FN_LOCK_ENTER = 3'd4;
    localparam logic [2:0] FN_LOCK_EXIT  = 3'd5;
    localparam logic [2:0] FN_START      = 3'd6;
    localparam logic [2:0] FN_SWITCH     = 3'd7;

    // cell commands
    localparam logic [2:0] CMD_NOP        = 3'd0;
    localparam logic [2:0] CMD_LINK       = 3'd1;
    localparam logic [2:0] CMD_LINK_KEEPQ = 3'd2;
    localparam logic [2:0] CMD_UNLINK     = 3'd3;
    localparam logic [2:0] CMD_ROTATE     = 3'd4;
    localparam logic [2:0] CMD_DEC        = 3'd5;

    typedef struct packed {
        logic [2:0]        op;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]  tag_new;
        logic [TAG_W-1:0]  tag_old;
    } prq_cmd_t;

    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]  tag;
    } prq_cand_t;

    typedef struct packed {
        logic             ready;
        logic             expire;
        logic [TAG_W-1:0] sel_tag;
    } prq_stat_t;

endpackage

FILE: rtl/core/prq_cell.sv
// ----------------------------------------------------------------------------
// prq_cell
// One thread slot: ready flag, priority, order tag and quantum counter, plus
// one stage of the best-thread search chain.
// ----------------------------------------------------------------------------
module prq_cell
    import prq_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [ID_W-1:0] cell_id,
    input  logic [ID_W-1:0] sel_id,
    input  prq_cmd_t        cmd,
    input  logic [QW-1:0]   reload,
    input  prq_cand_t       cand_in,
    output prq_cand_t       cand_out,
    output prq_stat_t       stat
);

    logic              ready_reg, ready_next;
    logic [PRIO_W-1:0] prio_reg, prio_next;
    logic [TAG_W-1:0]  tag_reg, tag_next;
    logic [QW-1:0]     quant_reg, quant_next;
    prq_cand_t         cand_reg, cand_next;

    logic mine;
    logic later;
    logic own_wins;

    always_comb
    begin
        mine       = (cell_id == cmd.id);
        later      = ready_reg && (tag_reg > cmd.tag_old);
        ready_next = ready_reg;
        prio_next  = prio_reg;
        tag_next   = tag_reg;
        quant_next = quant_reg;
        case (cmd.op)
            CMD_LINK:
            begin
                if (mine)
                begin
                    ready_next = 1'b1;
                    prio_next  = cmd.prio;
                    tag_next   = cmd.tag_new;
                    quant_next = reload;
                end
            end
            CMD_LINK_KEEPQ:
            begin
                if (mine)
                begin
                    ready_next = 1'b1;
                    prio_next  = cmd.prio;
                    tag_next   = cmd.tag_new;
                end
            end
            CMD_UNLINK:
            begin
                if (mine)
                    ready_next = 1'b0;
                else if (later)
                    tag_next = tag_reg - TAG_W'(1);
            end
            CMD_ROTATE:
            begin
                if (mine)
                begin
                    tag_next   = cmd.tag_new;
                    quant_next = reload;
                end
                else if (later)
                    tag_next = tag_reg - TAG_W'(1);
            end
            CMD_DEC:
            begin
                if (mine)
                    quant_next = quant_reg - QW'(1);
            end
            default:
            begin
            end
        endcase
    end

    // search stage: higher priority wins, then lower order tag
    always_comb
    begin
        own_wins = ready_reg && (!cand_in.valid || prio_reg > cand_in.prio ||
                   (prio_reg == cand_in.prio && tag_reg < cand_in.tag));
        cand_next = cand_in;
        if (own_wins)
        begin
            cand_next.valid = 1'b1;
            cand_next.id    = cell_id;
            cand_next.prio  = prio_reg;
            cand_next.tag   = tag_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg <= 1'b0;
            cand_reg  <= '0;
        end
        else
        begin
            ready_reg <= ready_next;
            cand_reg  <= cand_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prio_reg  <= prio_next;
        tag_reg   <= tag_next;
        quant_reg <= quant_next;
    end

    assign cand_out     = cand_reg;
    assign stat.ready   = ready_reg;
    assign stat.expire  = ready_reg && (quant_reg <= QW'(1));
    assign stat.sel_tag = (cell_id == sel_id) ? tag_reg : '0;

endmodule

FILE: rtl/core/priority_ready_queue_scheduler.sv
// ----------------------------------------------------------------------------
// priority_ready_queue_scheduler
// Ready queue of a kernel scheduler: a row of thread cells with a registered
// best-thread search chain, driven by a small request sequencer.
//
//   channel   handshake            payload
//   req       req_valid/req_stall  func, thread_id, new_priority
//   rsp       rsp_valid/rsp_stall  pending_*, current_*, dispatch_request,
//                                  ready_count, lock_depth, error
//   cfg       cfg_wr_en            cfg_wr_data (quantum_ticks)
//
// An item passes through the execute and output states; set priority adds a
// relink state. One that needs a best-thread search (remove of the pending
// thread, set priority of a pending current thread, a rotating tick of a
// pending current thread, start) also passes through the search state while
// the candidate ripples down the cell chain. req_stall is high while an item
// is in work. A stalled result holds in the output register and the next item
// is taken meanwhile. Reset clears all ready flags at once.
// ----------------------------------------------------------------------------
module priority_ready_queue_scheduler
    import prq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [2:0]  func,
    input  logic [3:0]  thread_id,
    input  logic [4:0]  new_priority,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [3:0]  pending_thread,
    output logic        pending_valid,
    output logic [3:0]  current_thread,
    output logic        current_valid,
    output logic        dispatch_request,
    output logic [4:0]  ready_count,
    output logic [7:0]  lock_depth,
    output logic        error,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_SEARCH = 3'd2;
    localparam logic [2:0] S_LINK2  = 3'd3;
    localparam logic [2:0] S_OUT    = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [2:0]        func_reg;
    logic [3:0]        tid_reg;
    logic [4:0]        nprio_reg;
    logic              err_reg, err_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ID_W-1:0]   pend_id_reg, pend_id_next;
    logic              pend_ok_reg, pend_ok_next;
    logic [PRIO_W-1:0] pend_prio_reg, pend_prio_next;
    logic [ID_W-1:0]   cur_id_reg, cur_id_next;
    logic              cur_ok_reg, cur_ok_next;
    logic              running_reg, running_next;
    logic [7:0]        lock_reg, lock_next;
    logic [QW-1:0]     quantum_reg;
    logic              rsp_valid_reg, rsp_valid_next;

    logic [3:0] pending_thread_reg;
    logic       pending_valid_reg;
    logic [3:0] current_thread_reg;
    logic       current_valid_reg;
    logic       dispatch_reg;
    logic [4:0] ready_count_reg;
    logic [7:0] lock_depth_reg;
    logic       error_reg;

    logic              load_out;
    logic              accept;
    logic [QW-1:0]     reload;
    logic [ID_W-1:0]   tid_idx;
    logic [PRIO_W-1:0] prio_int;
    logic              tid_ok;
    logic              prio_ok;
    logic              tid_ready;
    logic [ID_W-1:0]   sel_id;
    prq_cmd_t          cmd;
    prq_cand_t         cand_head;
    prq_cand_t         cand [THREADS];
    prq_stat_t         stat [THREADS];
    logic [THREADS-1:0] ready_vec;
    logic [THREADS-1:0] expire_vec;
    logic [TAG_W-1:0]  sel_tag;
    prq_cand_t         best;
    logic              cur_v;

    assign cand_head = '0;
    assign best      = cand[THREADS-1];

    genvar gi;
    generate
        for (gi = 0; gi < THREADS; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                prq_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .cell_id  (ID_W'(gi)),
                    .sel_id   (sel_id),
                    .cmd      (cmd),
                    .reload   (reload),
                    .cand_in  (cand_head),
                    .cand_out (cand[gi]),
                    .stat     (stat[gi])
                );
            end
            else
            begin : g_body
                prq_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .cell_id  (ID_W'(gi)),
                    .sel_id   (sel_id),
                    .cmd      (cmd),
                    .reload   (reload),
                    .cand_in  (cand[gi-1]),
                    .cand_out (cand[gi]),
                    .stat     (stat[gi])
                );
            end
        end
    endgenerate

    always_comb
    begin
        sel_tag = '0;
        for (int i = 0; i < THREADS; i++)
        begin
            ready_vec[i]  = stat[i].ready;
            expire_vec[i] = stat[i].expire;
            sel_tag       = sel_tag | stat[i].sel_tag;
        end
    end

    assign reload    = (quantum_reg == '0) ? QW'(1) : quantum_reg;
    assign tid_idx   = ID_W'(tid_reg);
    assign prio_int  = PRIO_W'(nprio_reg);
    assign tid_ok    = 32'(tid_reg) < THREADS;
    assign prio_ok   = 32'(nprio_reg) < PRIORITY_LEVELS;
    assign tid_ready = tid_ok && ready_vec[tid_idx];
    assign sel_id    = (func_reg == FN_REMOVE) ? tid_idx : cur_id_reg;
    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign cur_v     = running_reg && cur_ok_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        err_next       = err_reg;
        count_next     = count_reg;
        pend_id_next   = pend_id_reg;
        pend_ok_next   = pend_ok_reg;
        pend_prio_next = pend_prio_reg;
        cur_id_next    = cur_id_reg;
        cur_ok_next    = cur_ok_reg;
        running_next   = running_reg;
        lock_next      = lock_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        load_out       = 1'b0;
        cmd            = '0;
        cmd.op         = CMD_NOP;
        cmd.tag_old    = sel_tag;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_OUT;
                err_next   = 1'b0;
                cnt_next   = '0;
                case (func_reg)
                    FN_INSERT:
                    begin
                        if (!tid_ok || !prio_ok || tid_ready)
                            err_next = 1'b1;
                        else
                        begin
                            cmd.op      = CMD_LINK;
                            cmd.id      = tid_idx;
                            cmd.prio    = prio_int;
                            cmd.tag_new = TAG_W'(count_reg);
                            count_next  = count_reg + CNT_W'(1);
                            if (!pend_ok_reg || pend_prio_reg < prio_int)
                            begin
                                pend_id_next   = tid_idx;
                                pend_ok_next   = 1'b1;
                                pend_prio_next = prio_int;
                            end
                        end
                    end
                    FN_REMOVE:
                    begin
                        if (!tid_ready)
                            err_next = 1'b1;
                        else
                        begin
                            cmd.op     = CMD_UNLINK;
                            cmd.id     = tid_idx;
                            count_next = count_reg - CNT_W'(1);
                            if (pend_ok_reg && pend_id_reg == tid_idx)
                                state_next = S_SEARCH;
                        end
                    end
                    FN_SETPRIO:
                    begin
                        if (!running_reg || !cur_ok_reg || !prio_ok ||
                            !ready_vec[cur_id_reg])
                            err_next = 1'b1;
                        else
                        begin
                            cmd.op     = CMD_UNLINK;
                            cmd.id     = cur_id_reg;
                            count_next = count_reg - CNT_W'(1);
                            if (pend_ok_reg && pend_id_reg == cur_id_reg)
                                state_next = S_SEARCH;
                            else
                                state_next = S_LINK2;
                        end
                    end
                    FN_TICK:
                    begin
                        if (!running_reg)
                            err_next = 1'b1;
                        else if (lock_reg == 8'd0 && cur_ok_reg &&
                                 ready_vec[cur_id_reg])
                        begin
                            cmd.id = cur_id_reg;
                            if (expire_vec[cur_id_reg])
                            begin
                                cmd.op      = CMD_ROTATE;
                                cmd.tag_new = TAG_W'(count_reg - CNT_W'(1));
                                if (pend_ok_reg && pend_id_reg == cur_id_reg)
                                    state_next = S_SEARCH;
                            end
                            else
                                cmd.op = CMD_DEC;
                        end
                    end
                    FN_LOCK_ENTER:
                    begin
                        if (lock_reg == 8'hFF)
                            err_next = 1'b1;
                        else
                            lock_next = lock_reg + 8'd1;
                    end
                    FN_LOCK_EXIT:
                    begin
                        if (lock_reg == 8'd0)
                            err_next = 1'b1;
                        else
                            lock_next = lock_reg - 8'd1;
                    end
                    FN_START:
                    begin
                        if (running_reg || count_reg == '0)
                            err_next = 1'b1;
                        else
                            state_next = S_SEARCH;
                    end
                    default:
                    begin
                        if (!running_reg || !pend_ok_reg)
                            err_next = 1'b1;
                        else
                        begin
                            cur_id_next = pend_id_reg;
                            cur_ok_next = 1'b1;
                        end
                    end
                endcase
            end
            S_SEARCH:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(THREADS))
                begin
                    state_next = S_OUT;
                    case (func_reg)
                        FN_REMOVE, FN_SETPRIO:
                        begin
                            pend_ok_next   = best.valid;
                            pend_id_next   = best.valid ? best.id : '0;
                            pend_prio_next = best.prio;
                            if (func_reg == FN_SETPRIO)
                                state_next = S_LINK2;
                        end
                        FN_TICK:
                        begin
                            if (best.valid)
                            begin
                                pend_id_next   = best.id;
                                pend_prio_next = best.prio;
                            end
                        end
                        FN_START:
                        begin
                            cur_id_next    = best.id;
                            cur_ok_next    = 1'b1;
                            pend_id_next   = best.id;
                            pend_ok_next   = 1'b1;
                            pend_prio_next = best.prio;
                            running_next   = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_LINK2:
            begin
                cmd.op      = CMD_LINK_KEEPQ;
                cmd.id      = cur_id_reg;
                cmd.prio    = prio_int;
                cmd.tag_new = TAG_W'(count_reg);
                count_next  = count_reg + CNT_W'(1);
                if (!pend_ok_reg || pend_prio_reg < prio_int)
                begin
                    pend_id_next   = cur_id_reg;
                    pend_ok_next   = 1'b1;
                    pend_prio_next = prio_int;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    load_out       = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            count_reg     <= '0;
            pend_id_reg   <= '0;
            pend_ok_reg   <= 1'b0;
            cur_id_reg    <= '0;
            cur_ok_reg    <= 1'b0;
            running_reg   <= 1'b0;
            lock_reg      <= 8'd0;
            quantum_reg   <= QUANTUM_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            count_reg     <= count_next;
            pend_id_reg   <= pend_id_next;
            pend_ok_reg   <= pend_ok_next;
            cur_id_reg    <= cur_id_next;
            cur_ok_reg    <= cur_ok_next;
            running_reg   <= running_next;
            lock_reg      <= lock_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_wr_en)
                quantum_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg       <= err_next;
        pend_prio_reg <= pend_prio_next;
        if (accept)
        begin
            func_reg  <= func;
            tid_reg   <= thread_id;
            nprio_reg <= new_priority;
        end
        if (load_out)
        begin
            pending_thread_reg <= pend_ok_reg ? 4'(pend_id_reg) : 4'd0;
            pending_valid_reg  <= pend_ok_reg;
            current_thread_reg <= cur_v ? 4'(cur_id_reg) : 4'd0;
            current_valid_reg  <= cur_v;
            dispatch_reg       <= running_reg && (lock_reg == 8'd0) && pend_ok_reg &&
                                  (!cur_v || pend_id_reg != cur_id_reg);
            ready_count_reg    <= 5'(count_reg);
            lock_depth_reg     <= lock_reg;
            error_reg          <= err_reg;
        end
    end

    assign rsp_valid        = rsp_valid_reg;
    assign pending_thread   = pending_thread_reg;
    assign pending_valid    = pending_valid_reg;
    assign current_thread   = current_thread_reg;
    assign current_valid    = current_valid_reg;
    assign dispatch_request = dispatch_reg;
    assign ready_count      = ready_count_reg;
    assign lock_depth       = lock_depth_reg;
    assign error            = error_reg;

    // ready count tracks the cell flags
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) == $countones(ready_vec))
        else $error("ready count out of step with cell flags");

    // between items a valid pending thread is ready
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && pend_ok_reg) |-> ready_vec[pend_id_reg])
        else $error("pending thread not ready");

    // an accepted item is executed in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_EXEC))
        else $error("accepted item not executed");

    // once started there is a current thread
    assert property (@(posedge clk) disable iff (!rst_n)
        running_reg |-> cur_ok_reg)
        else $error("started without current thread");

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: priority_ready_queue_scheduler
// Drives scheduler requests through the req channel and checks every status
// item on the rsp channel against a cycle-free model of the ready queue
// (priority, ready order, quanta, pending/current, lock depth). The run covers
// directed corner cases, lock saturation, several quantum settings, a long
// response hold-off and a final stretch without idling.
// ----------------------------------------------------------------------------
module testbench;
    import prq_pkg::*;

    typedef struct packed {
        logic [ID_W-1:0]   pend;
        logic              pend_v;
        logic [ID_W-1:0]   cur;
        logic              cur_v;
        logic              disp;
        logic [CNT_W-1:0]  count;
        logic [7:0]        depth;
        logic              err;
    } sched_status_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              req_valid;
    logic              req_stall;
    logic [2:0]        func;
    logic [3:0]        thread_id;
    logic [4:0]        new_priority;
    logic              rsp_valid;
    logic              rsp_stall;
    logic [3:0]        pending_thread;
    logic              pending_valid;
    logic [3:0]        current_thread;
    logic              current_valid;
    logic              dispatch_request;
    logic [4:0]        ready_count;
    logic [7:0]        lock_depth;
    logic              error;
    logic              cfg_wr_en;
    logic [15:0]       cfg_wr_data;

    // model state
    logic [THREADS-1:0] ready_mask;
    logic [PRIO_W-1:0]  prio_of [THREADS];
    int                 rank_of [THREADS];
    logic [QW-1:0]      slice_left [THREADS];
    logic [QW-1:0]      quantum_cfg;
    logic [ID_W-1:0]    next_id;
    logic               next_ok;
    logic [ID_W-1:0]    run_id;
    logic               run_ok;
    logic               started;
    logic [7:0]         lock_level;

    sched_status_t expected_status [$];
    int            mismatches = 0;
    bit            quiet      = 1'b0;
    bit            hold_rsp   = 1'b0;

    priority_ready_queue_scheduler dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .req_valid        (req_valid),
        .req_stall        (req_stall),
        .func             (func),
        .thread_id        (thread_id),
        .new_priority     (new_priority),
        .rsp_valid        (rsp_valid),
        .rsp_stall        (rsp_stall),
        .pending_thread   (pending_thread),
        .pending_valid    (pending_valid),
        .current_thread   (current_thread),
        .current_valid    (current_valid),
        .dispatch_request (dispatch_request),
        .ready_count      (ready_count),
        .lock_depth       (lock_depth),
        .error            (error),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data)
    );

    always #5 clk = ~clk;

    function automatic logic [QW-1:0] reload_ticks();
        return (quantum_cfg == '0) ? QW'(1) : quantum_cfg;
    endfunction

    // highest priority, then earliest in ready order
    function automatic logic pick_best(output logic [ID_W-1:0] who);
        logic found;
        found = 1'b0;
        who   = '0;
        for (int i = 0; i < THREADS; i++)
        begin
            if (ready_mask[i] && (!found || prio_of[i] > prio_of[who] ||
                (prio_of[i] == prio_of[who] && rank_of[i] < rank_of[who])))
            begin
                who   = ID_W'(i);
                found = 1'b1;
            end
        end
        return found;
    endfunction

    function automatic void leave_order(input logic [ID_W-1:0] t);
        for (int i = 0; i < THREADS; i++)
            if (ready_mask[i] && i != t && rank_of[i] > rank_of[t])
                rank_of[i]--;
        ready_mask[t] = 1'b0;
    endfunction

    function automatic void join_order(input logic [ID_W-1:0] t,
                                       input logic [PRIO_W-1:0] p);
        rank_of[t]    = $countones(ready_mask);
        prio_of[t]    = p;
        ready_mask[t] = 1'b1;
    endfunction

    function automatic void make_ready(input logic [ID_W-1:0] t,
                                       input logic [PRIO_W-1:0] p);
        join_order(t, p);
        if (!next_ok || prio_of[next_id] < p)
        begin
            next_id = t;
            next_ok = 1'b1;
        end
    endfunction

    function automatic void make_unready(input logic [ID_W-1:0] t);
        logic [ID_W-1:0] b;
        leave_order(t);
        if (next_ok && next_id == t)
        begin
            next_ok = pick_best(b);
            next_id = next_ok ? b : '0;
        end
    endfunction

    function automatic sched_status_t apply_request(input logic [2:0] f,
                                                    input logic [ID_W-1:0] t,
                                                    input logic [PRIO_W-1:0] p);
        sched_status_t   r;
        logic            err;
        logic            cur_v;
        logic [ID_W-1:0] b;
        logic [QW-1:0]   q;
        err = 1'b0;
        case (f)
            FN_INSERT:
                if (ready_mask[t])
                    err = 1'b1;
                else
                begin
                    slice_left[t] = reload_ticks();
                    make_ready(t, p);
                end
            FN_REMOVE:
                if (!ready_mask[t])
                    err = 1'b1;
                else
                    make_unready(t);
            FN_SETPRIO:
                if (!started || !run_ok || !ready_mask[run_id])
                    err = 1'b1;
                else
                begin
                    make_unready(run_id);
                    make_ready(run_id, p);
                end
            FN_TICK:
                if (!started)
                    err = 1'b1;
                else if (lock_level == 8'd0 && run_ok && ready_mask[run_id])
                begin
                    q = slice_left[run_id];
                    if (q != '0)
                        q = q - QW'(1);
                    if (q == '0)
                    begin
                        slice_left[run_id] = reload_ticks();
                        leave_order(run_id);
                        join_order(run_id, prio_of[run_id]);
                        if (next_ok && next_id == run_id && pick_best(b))
                            next_id = b;
                    end
                    else
                        slice_left[run_id] = q;
                end
            FN_LOCK_ENTER:
                if (lock_level == 8'hFF)
                    err = 1'b1;
                else
                    lock_level++;
            FN_LOCK_EXIT:
                if (lock_level == 8'd0)
                    err = 1'b1;
                else
                    lock_level--;
            FN_START:
                if (started || !pick_best(b))
                    err = 1'b1;
                else
                begin
                    run_id  = b;
                    run_ok  = 1'b1;
                    next_id = b;
                    next_ok = 1'b1;
                    started = 1'b1;
                end
            default:
                if (!started || !next_ok)
                    err = 1'b1;
                else
                begin
                    run_id = next_id;
                    run_ok = 1'b1;
                end
        endcase
        cur_v    = started && run_ok;
        r.pend   = next_ok ? next_id : '0;
        r.pend_v = next_ok;
        r.cur    = cur_v ? run_id : '0;
        r.cur_v  = cur_v;
        r.disp   = started && lock_level == 8'd0 && next_ok && (!cur_v || next_id != run_id);
        r.count  = CNT_W'($countones(ready_mask));
        r.depth  = lock_level;
        r.err    = err;
        return r;
    endfunction

    function automatic logic [ID_W-1:0] random_thread(input logic want_ready);
        int              first;
        logic [ID_W-1:0] id;
        first = $urandom_range(0, THREADS - 1);
        id    = ID_W'(first);
        for (int i = 0; i < THREADS; i++)
        begin
            id = ID_W'((first + i) % THREADS);
            if (ready_mask[id] == want_ready)
                return id;
        end
        return id;
    endfunction

    task automatic send_item(input logic [2:0] f, input logic [3:0] t,
                             input logic [4:0] p, input bit gaps);
        req_valid    <= 1'b1;
        func         <= f;
        thread_id    <= t;
        new_priority <= p;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        expected_status.push_back(apply_request(f, t, p));
        if (gaps && !quiet && $urandom_range(0, 4) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        req_valid <= 1'b0;
        while (expected_status.size() != 0)
            @(posedge clk);
        repeat (24) @(posedge clk);
    endtask

    task automatic set_quantum(input logic [15:0] v);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        quantum_cfg = v;
    endtask

    task automatic send_random(input int n, input bit gaps);
        int          r;
        int          nready;
        logic [2:0]  f;
        logic [3:0]  t;
        logic [4:0]  p;
        for (int k = 0; k < n; k++)
        begin
            r      = $urandom_range(0, 99);
            nready = $countones(ready_mask);
            f      = FN_TICK;
            t      = 4'($urandom_range(0, 15));
            p      = ($urandom_range(0, 1) != 0) ? 5'($urandom_range(0, 3)) :
                                                   5'($urandom_range(0, 31));
            if (r < 12)
                f = 3'($urandom_range(0, 7));
            else if ((nready < 3 || r < 32) && nready < THREADS)
            begin
                f = FN_INSERT;
                t = random_thread(1'b0);
            end
            else if (r < 42 && nready > 0)
            begin
                f = FN_REMOVE;
                t = random_thread(1'b1);
            end
            else if (r < 52)
            begin
                if (run_ok && !ready_mask[run_id] && nready < THREADS)
                begin
                    f = FN_INSERT;
                    t = run_id;
                end
                else
                    f = FN_SETPRIO;
            end
            else if (r < 60)
                f = (lock_level < 8'd3) ? FN_LOCK_ENTER : FN_LOCK_EXIT;
            else if (r < 68 && lock_level > 8'd0)
                f = FN_LOCK_EXIT;
            else if (r < 78)
                f = FN_SWITCH;
            send_item(f, t, p, gaps);
        end
    endtask

    task automatic test_directed();
        set_quantum(16'd2);
        send_item(FN_LOCK_EXIT,  4'd0,  5'd0,  1'b1);
        send_item(FN_TICK,       4'd0,  5'd0,  1'b1);
        send_item(FN_SETPRIO,    4'd0,  5'd31, 1'b1);
        send_item(FN_SWITCH,     4'd0,  5'd0,  1'b1);
        send_item(FN_START,      4'd0,  5'd0,  1'b1);
        send_item(FN_REMOVE,     4'd3,  5'd0,  1'b1);
        send_item(FN_LOCK_ENTER, 4'd0,  5'd0,  1'b1);
        send_item(FN_LOCK_EXIT,  4'd0,  5'd0,  1'b1);
        send_item(FN_INSERT,     4'd0,  5'd0,  1'b1);
        send_item(FN_INSERT,     4'd15, 5'd31, 1'b1);
        send_item(FN_INSERT,     4'd15, 5'd7,  1'b1);
        send_item(FN_INSERT,     4'd5,  5'd31, 1'b1);
        send_item(FN_INSERT,     4'd9,  5'd10, 1'b1);
        send_item(FN_REMOVE,     4'd9,  5'd0,  1'b1);
        send_item(FN_START,      4'd0,  5'd0,  1'b1);
        send_item(FN_SWITCH,     4'd0,  5'd0,  1'b1);
        send_item(FN_TICK,       4'd0,  5'd0,  1'b1);
        send_item(FN_TICK,       4'd0,  5'd0,  1'b1);
        send_item(FN_SWITCH,     4'd0,  5'd0,  1'b1);
        send_item(FN_LOCK_ENTER, 4'd0,  5'd0,  1'b1);
        send_item(FN_TICK,       4'd0,  5'd0,  1'b1);
        send_item(FN_LOCK_EXIT,  4'd0,  5'd0,  1'b1);
        send_item(FN_SETPRIO,    4'd0,  5'd0,  1'b1);
        send_item(FN_SWITCH,     4'd0,  5'd0,  1'b1);
        send_item(FN_REMOVE,     4'd15, 5'd0,  1'b1);
        send_item(FN_TICK,       4'd0,  5'd0,  1'b1);
        send_item(FN_SETPRIO,    4'd0,  5'd3,  1'b1);
        send_item(FN_START,      4'd0,  5'd0,  1'b1);
    endtask

    // saturate the lock at its top, then unwind past zero
    task automatic test_lock_depth();
        for (int k = 0; k < 256; k++)
            send_item(FN_LOCK_ENTER, 4'($urandom_range(0, 15)),
                      5'($urandom_range(0, 31)), 1'b1);
        for (int k = 0; k < 256; k++)
            send_item(FN_LOCK_EXIT, 4'($urandom_range(0, 15)),
                      5'($urandom_range(0, 31)), 1'b1);
    endtask

    task automatic test_quantum_sweep();
        set_quantum(16'd1);
        send_random(24, 1'b1);
        set_quantum(16'd0);
        send_random(24, 1'b1);
        set_quantum(16'd3);
        send_random(24, 1'b1);
        set_quantum(16'hFFFF);
        send_random(24, 1'b1);
        set_quantum(16'($urandom_range(1, 65535)));
        send_random(24, 1'b1);
    endtask

    task automatic test_backpressure();
        set_quantum(16'($urandom_range(1, 4)));
        hold_rsp = 1'b1;
        send_random(40, 1'b0);
        wait_idle();
    endtask

    task automatic test_final_stretch();
        quiet = 1'b1;
        set_quantum(16'($urandom_range(1, 8)));
        send_random(50, 1'b0);
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : check_results
        sched_status_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_status.size() == 0)
            begin
                $error("status item with nothing expected");
                mismatches++;
            end
            else
            begin
                want = expected_status.pop_front();
                check_field("pending_thread",   8'(want.pend),   8'(pending_thread));
                check_field("pending_valid",    8'(want.pend_v), 8'(pending_valid));
                check_field("current_thread",   8'(want.cur),    8'(current_thread));
                check_field("current_valid",    8'(want.cur_v),  8'(current_valid));
                check_field("dispatch_request", 8'(want.disp),   8'(dispatch_request));
                check_field("ready_count",      8'(want.count),  8'(ready_count));
                check_field("lock_depth",       want.depth,      lock_depth);
                check_field("error",            8'(want.err),    8'(error));
            end
        end
    end

    // receiver: random stall bursts, one long hold-off on request
    initial
    begin
        rsp_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_rsp)
            begin
                rsp_stall <= 1'b1;
                repeat (400) @(posedge clk);
                hold_rsp = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            else
            begin
                rsp_stall <= 1'b0;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    initial
    begin
        #4_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    initial
    begin
        rst_n        <= 1'b0;
        req_valid    <= 1'b0;
        func         <= FN_INSERT;
        thread_id    <= '0;
        new_priority <= '0;
        cfg_wr_en    <= 1'b0;
        cfg_wr_data  <= '0;
        ready_mask   = '0;
        for (int i = 0; i < THREADS; i++)
        begin
            prio_of[i]    = '0;
            rank_of[i]    = 0;
            slice_left[i] = '0;
        end
        quantum_cfg = QUANTUM_RESET;
        next_id     = '0;
        next_ok     = 1'b0;
        run_id      = '0;
        run_ok      = 1'b0;
        started     = 1'b0;
        lock_level  = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_lock_depth();
        test_quantum_sweep();
        test_backpressure();
        test_final_stretch();
        wait_idle();

        if (mismatches == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
